@@ hw/rtl/pce_pkg.sv @@
`default_nettype none

package pce_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_CRC_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_POLYNOMIAL  = 3'd1;
    localparam logic [2:0] CFG_INITIAL_CRC = 3'd2;
    localparam logic [2:0] CFG_REFLECTED   = 3'd3;
    localparam logic [2:0] CFG_REVERSE_OUT = 3'd4;
    localparam logic [2:0] CFG_FINAL_XOR   = 3'd5;

    localparam int CRC_MAX_W  = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int WIDTH_W    = 7;
    localparam int DATA_W     = 8;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd32;

    // Configuration set handed to the fold datapath
    typedef struct packed {
        logic [WIDTH_W-1:0]   crc_width;
        logic [CRC_MAX_W-1:0] polynomial;
        logic [CRC_MAX_W-1:0] initial_crc;
        logic                 reflected;
        logic                 reverse_out;
        logic [CRC_MAX_W-1:0] final_xor;
    } t_cfg;

    // Full-width bit reversal (pure wiring)
    function automatic logic [CRC_MAX_W-1:0] rev64(input logic [CRC_MAX_W-1:0] x);
        logic [CRC_MAX_W-1:0] y;
        for (int i = 0; i < CRC_MAX_W; i++) begin
            y[i] = x[CRC_MAX_W-1-i];
        end
        return y;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pce_fold.sv @@
`default_nettype none

module pce_fold (
    input  wire pce_pkg::t_cfg              i_cfg,
    input  wire logic [pce_pkg::DATA_W-1:0] i_data_byte,
    input  wire logic                       i_start_req,
    input  wire logic [pce_pkg::CRC_MAX_W-1:0] i_crc_cur,
    output logic [pce_pkg::CRC_MAX_W-1:0]   o_crc_next
);
    import pce_pkg::*;

    logic [WIDTH_W-1:0]   w_width;
    logic [WIDTH_W-1:0]   w_gap;
    logic [5:0]           w_sh;
    logic [CRC_MAX_W-1:0] w_mask;
    logic [CRC_MAX_W-1:0] w_poly;
    logic [CRC_MAX_W-1:0] w_poly_al;
    logic [CRC_MAX_W-1:0] w_xo;
    logic [CRC_MAX_W-1:0] w_c;

    // Effective width: 0 acts as 1, anything above 64 acts as 64
    always_comb begin
        if (i_cfg.crc_width == '0) begin
            w_width = 7'd1;
        end else if (i_cfg.crc_width > 7'(CRC_MAX_W)) begin
            w_width = 7'(CRC_MAX_W);
        end else begin
            w_width = i_cfg.crc_width;
        end
        w_gap     = 7'(CRC_MAX_W) - w_width;
        w_sh      = w_gap[5:0];
        w_mask    = {CRC_MAX_W{1'b1}} >> w_sh;
        w_poly    = i_cfg.polynomial & w_mask;
        w_poly_al = w_poly << w_sh;
        w_xo      = i_cfg.final_xor & w_mask;
    end

    // One byte through the generator, eight bit steps.
    // Unreflected mode works left-aligned at bit 63, so every width shares one path.
    always_comb begin
        w_c = ((i_start_req ? i_cfg.initial_crc : i_crc_cur) & w_mask) ^ w_xo;
        if (i_cfg.reflected) begin
            if (i_cfg.reverse_out) begin
                w_c = rev64(w_c) >> w_sh;
            end
            w_c = w_c ^ {{(CRC_MAX_W-DATA_W){1'b0}}, i_data_byte};
            for (int k = 0; k < DATA_W; k++) begin
                w_c = w_c[0] ? ((w_c >> 1) ^ w_poly) : (w_c >> 1);
            end
            w_c = w_c & w_mask;
            if (i_cfg.reverse_out) begin
                w_c = rev64(w_c) >> w_sh;
            end
        end else begin
            // reversed value of a masked word is already left-aligned
            w_c = i_cfg.reverse_out ? rev64(w_c) : (w_c << w_sh);
            w_c = w_c ^ {i_data_byte, {(CRC_MAX_W-DATA_W){1'b0}}};
            for (int k = 0; k < DATA_W; k++) begin
                w_c = w_c[CRC_MAX_W-1] ? ((w_c << 1) ^ w_poly_al) : (w_c << 1);
            end
            w_c = i_cfg.reverse_out ? (rev64(w_c) & w_mask) : (w_c >> w_sh);
        end
        o_crc_next = (w_c ^ w_xo) & w_mask;
    end

endmodule

`default_nettype wire

@@ hw/rtl/parameterized_crc_engine_top.sv @@
// Byte-serial CRC engine, any width from 1 to 64 bits.
//
// Input channel (i_in_valid / o_in_ready): one message byte per item, with
// i_start_req to reload the running CRC from the initial value first, and
// i_final_req to mark the last byte. Output channel (o_out_valid /
// i_out_ready): one result per item, the finished CRC of the bytes so far in
// o_crc_value (bits above the width are zero), and o_is_final echoing the flag.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): register
// index and data; write only while no item is in flight.
//
// Two stages: input register, then result register. Throughput is one item
// per cycle while the receiver keeps up; the fold of eight bits is a single
// combinational pass. If the receiver stalls, the result holds and one more
// item is still taken into the input register; after that o_in_ready drops
// until the result moves.
// Reset (synchronous, active low) empties both stages, sets the running CRC to
// zero and restores the configuration defaults (width 32, all else zero).
`default_nettype none

module parameterized_crc_engine_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [pce_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [pce_pkg::CRC_MAX_W-1:0]       i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [pce_pkg::DATA_W-1:0]          i_data_byte,
    input  wire logic                                i_start_req,
    input  wire logic                                i_final_req,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [pce_pkg::CRC_MAX_W-1:0]            o_crc_value,
    output logic                                     o_is_final
);
    import pce_pkg::*;

    t_cfg                 r_cfg;
    logic                 r_in_valid;
    logic [DATA_W-1:0]    r_in_byte;
    logic                 r_in_start;
    logic                 r_in_final;
    logic                 r_out_valid;
    logic                 r_out_final;
    logic [CRC_MAX_W-1:0] r_crc;
    logic [CRC_MAX_W-1:0] n_crc;
    logic                 w_move;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_width   <= WIDTH_RESET;
            r_cfg.polynomial  <= '0;
            r_cfg.initial_crc <= '0;
            r_cfg.reflected   <= 1'b0;
            r_cfg.reverse_out <= 1'b0;
            r_cfg.final_xor   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CRC_WIDTH:   r_cfg.crc_width   <= i_cfg_data[WIDTH_W-1:0];
                CFG_POLYNOMIAL:  r_cfg.polynomial  <= i_cfg_data;
                CFG_INITIAL_CRC: r_cfg.initial_crc <= i_cfg_data;
                CFG_REFLECTED:   r_cfg.reflected   <= i_cfg_data[0];
                CFG_REVERSE_OUT: r_cfg.reverse_out <= i_cfg_data[0];
                CFG_FINAL_XOR:   r_cfg.final_xor   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Stage handshake: item moves from input register to result register
    assign w_move     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_move;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_start_req;
            r_in_final <= i_final_req;
        end
    end

    // Fold one byte into the running CRC
    pce_fold u_fold (
        .i_cfg       (r_cfg),
        .i_data_byte (r_in_byte),
        .i_start_req (r_in_start),
        .i_crc_cur   (r_crc),
        .o_crc_next  (n_crc)
    );

    // Result register; the running CRC doubles as the output value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_crc       <= '0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
            r_crc       <= n_crc;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_final <= r_in_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_crc;
    assign o_is_final  = r_out_final;

endmodule

`default_nettype wire

@@ hw/rtl/pce_checker.sv @@
`default_nettype none

module pce_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          o_cfg_ready,
    input  wire logic                          o_in_ready,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [pce_pkg::CRC_MAX_W-1:0] o_crc_value,
    input  wire logic                          o_is_final
);

    // Stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // Stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_crc_value) && $stable(o_is_final))
        else $error("result changed while stalled");

    // Input back-pressure only comes from a stalled result with one item queued
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input not ready without an output stall");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Configuration writes are never refused
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind parameterized_crc_engine_top pce_checker u_pce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_crc_value (o_crc_value),
    .o_is_final  (o_is_final)
);

`default_nettype wire
